@@ sv/sprle_pkg.sv @@
// Shared types and constants for the sample packer and run-length encoder.
// Used by every module of the block but sprle_ram; depends on nothing else.
package sprle_pkg;

  localparam int unsigned RUN_MAX = 32;
  localparam int unsigned CNT_W = $clog2(RUN_MAX + 1);
  localparam int unsigned ADDR_W = $clog2(RUN_MAX);
  localparam int unsigned SEEN_W = 6;
  localparam logic [SEEN_W-1:0] SEEN_SAT = '1;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic {
    REG_BPS = 1'b0,
    REG_RLE = 1'b1
  } reg_e;

  typedef struct packed {
    logic [7:0] sample_value;
    logic       end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_burst;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic take;
    logic direct;
    logic code;
    logic hdr;
    logic val;
    logic lit;
    logic post;
    logic flush;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic slot_pending;
    logic flush_pending;
    logic rle;
    logic needs_emit;
    logic repeat_mode;
    logic lit_last;
    logic emit_ok;
  } stat_t;

endpackage

@@ sv/sprle_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the run-length coder's byte buffer.
module sprle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sprle_ctrl.sv @@
// Sequencer of the sample packer and run-length encoder.
// Depends on sprle_pkg; drives the datapath through cmd_t and reads stat_t.
module sprle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sprle_pkg::stat_t stat_i,
  output sprle_pkg::cmd_t  cmd_o
);
  import sprle_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_NEXT = 6'b000010,
    ST_PASS = 6'b000100,
    ST_HDR  = 6'b001000,
    ST_VAL  = 6'b010000,
    ST_LIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        priority if (stat_i.slot_pending) begin
          cmd_o.take = 1'b1;
          state_d = ST_PASS;
        end else if (stat_i.flush_pending) begin
          cmd_o.flush = 1'b1;
          state_d = ST_HDR;
        end else if (stat_i.emit_ok) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_PASS: begin
        priority if (stat_i.rle) begin
          cmd_o.code = 1'b1;
          state_d = stat_i.needs_emit ? ST_HDR : ST_NEXT;
        end else if (stat_i.emit_ok) begin
          cmd_o.direct = 1'b1;
          state_d = ST_NEXT;
        end else begin
          state_d = ST_PASS;
        end
      end
      ST_HDR: begin
        if (stat_i.emit_ok) begin
          cmd_o.hdr = 1'b1;
          state_d = stat_i.repeat_mode ? ST_VAL : ST_LIT;
        end
      end
      ST_VAL: begin
        if (stat_i.emit_ok) begin
          cmd_o.val = 1'b1;
          cmd_o.post = 1'b1;
          state_d = ST_NEXT;
        end
      end
      ST_LIT: begin
        if (stat_i.emit_ok) begin
          cmd_o.lit = 1'b1;
          if (stat_i.lit_last) begin
            cmd_o.post = 1'b1;
            state_d = ST_NEXT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/sprle_dp.sv @@
// Datapath: bit packer, run-length coder state, byte buffer and output stage.
// Depends on sprle_pkg and sprle_ram; commanded by sprle_ctrl.
module sprle_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sprle_pkg::cmd_t      cmd_i,
  output sprle_pkg::stat_t     stat_o,
  input  sprle_pkg::in_item_t  in_data_i,
  input  logic [3:0]           bps_i,
  input  logic                 rle_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sprle_pkg::out_item_t out_data_o
);
  import sprle_pkg::*;

  typedef enum logic [1:0] {
    POST_NONE  = 2'd0,
    POST_START = 2'd1,
    POST_SET   = 2'd2
  } post_e;

  logic [7:0]        pack_q, pack_d;
  logic [3:0]        fill_q, fill_d;
  logic              slot0_v_q, slot0_v_d, slot1_v_q, slot1_v_d;
  logic [7:0]        slot0_b_q, slot0_b_d, slot1_b_q, slot1_b_d;
  logic              eor_q, eor_d;
  logic [7:0]        cb_q, cb_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              repeat_q, repeat_d;
  logic [7:0]        rv_q, rv_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  post_e             post_q, post_d;
  logic              hold_v_q, hold_v_d;
  logic [7:0]        hold_b_q, hold_b_d;
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;

  logic [3:0]        w;
  logic [8:0]        mask9;
  logic [7:0]        v8;
  logic              pre;
  logic [7:0]        base_b, new_b;
  logic [3:0]        base_f, new_f;
  logic              pass1;

  logic              eq, full, rep_end, lit_switch, needs_emit;
  logic [SEEN_W-1:0] seen_n, drop, cnt_ext;
  logic [CNT_W-1:0]  cnt_cut, set_count;

  logic              emit, emit_ok;
  logic [7:0]        emit_b;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  always_comb begin
    unique case (bps_i)
      4'd1:    w = 4'd1;
      4'd2:    w = 4'd2;
      4'd4:    w = 4'd4;
      default: w = 4'd8;
    endcase
    mask9 = (9'd1 << w) - 9'd1;
    v8 = in_data_i.sample_value & mask9[7:0];
    pre = (5'(fill_q) + 5'(w)) > 5'd8;
    base_b = pre ? 8'd0 : pack_q;
    base_f = pre ? 4'd0 : fill_q;
    new_f = base_f + w;
    new_b = base_b | (v8 << (4'd8 - new_f));
    pass1 = new_f[3] | (in_data_i.end_of_row & (new_f != 4'd0));
  end

  always_comb begin
    eq = (cb_q == rv_q);
    full = (count_q >= CNT_W'(RUN_MAX));
    seen_n = (seen_q == SEEN_SAT) ? seen_q : seen_q + SEEN_W'(1);
    drop = seen_n - SEEN_W'(1);
    cnt_ext = SEEN_W'(count_q);
    cnt_cut = (cnt_ext > drop) ? CNT_W'(cnt_ext - drop) : '0;
    set_count = (seen_q > SEEN_W'(RUN_MAX)) ? CNT_W'(RUN_MAX) : CNT_W'(seen_q);
    rep_end = repeat_q & (count_q > CNT_W'(2)) & !eq;
    lit_switch = !repeat_q & eq & (seen_n > SEEN_W'(3));
    needs_emit = full | rep_end | lit_switch;
  end

  assign emit = cmd_i.direct | cmd_i.hdr | cmd_i.val | cmd_i.lit;
  assign emit_ok = !hold_v_q | !out_v_q | !out_stall_i;

  always_comb begin
    priority if (cmd_i.hdr) begin
      emit_b = repeat_q ? (8'd0 - 8'(count_q)) : (8'(count_q) - 8'd1);
    end else if (cmd_i.val) begin
      emit_b = rv_q;
    end else if (cmd_i.lit) begin
      emit_b = ram_rdata;
    end else begin
      emit_b = cb_q;
    end
  end

  always_comb begin
    pack_d = pack_q;
    fill_d = fill_q;
    slot0_v_d = slot0_v_q;
    slot0_b_d = slot0_b_q;
    slot1_v_d = slot1_v_q;
    slot1_b_d = slot1_b_q;
    eor_d = eor_q;
    cb_d = cb_q;
    count_d = count_q;
    repeat_d = repeat_q;
    rv_d = rv_q;
    seen_d = seen_q;
    idx_d = idx_q;
    post_d = post_q;
    hold_v_d = hold_v_q;
    hold_b_d = hold_b_q;
    out_v_d = out_v_q & out_stall_i;
    out_d = out_q;
    ram_we = 1'b0;
    ram_waddr = count_q[ADDR_W-1:0];
    ram_wdata = cb_q;

    if (cmd_i.accept) begin
      slot0_v_d = pre;
      slot0_b_d = pack_q;
      slot1_v_d = pass1;
      slot1_b_d = new_b;
      pack_d = pass1 ? 8'd0 : new_b;
      fill_d = pass1 ? 4'd0 : new_f;
      eor_d = in_data_i.end_of_row;
    end

    if (cmd_i.take) begin
      if (slot0_v_q) begin
        cb_d = slot0_b_q;
        slot0_v_d = 1'b0;
      end else begin
        cb_d = slot1_b_q;
        slot1_v_d = 1'b0;
      end
    end

    if (cmd_i.code) begin
      if (needs_emit) begin
        priority if (full || rep_end) begin
          post_d = POST_START;
        end else begin
          seen_d = seen_n;
          count_d = cnt_cut;
          post_d = POST_SET;
        end
      end else begin
        ram_we = 1'b1;
        count_d = count_q + CNT_W'(1);
        if (repeat_q) begin
          if (count_q == '0) begin
            rv_d = cb_q;
          end else if (!eq) begin
            repeat_d = 1'b0;
            rv_d = cb_q;
            seen_d = SEEN_W'(1);
          end
        end else if (eq) begin
          seen_d = seen_n;
        end else begin
          rv_d = cb_q;
          seen_d = SEEN_W'(1);
        end
      end
    end

    if (cmd_i.flush) begin
      post_d = POST_NONE;
      eor_d = 1'b0;
    end

    if (cmd_i.finish) begin
      eor_d = 1'b0;
    end

    if (cmd_i.hdr) begin
      idx_d = '0;
    end
    if (cmd_i.lit) begin
      idx_d = idx_q + CNT_W'(1);
    end

    if (cmd_i.post) begin
      repeat_d = 1'b1;
      unique case (post_q)
        POST_START: begin
          rv_d = cb_q;
          ram_we = 1'b1;
          ram_waddr = '0;
          count_d = CNT_W'(1);
        end
        POST_SET: begin
          count_d = set_count;
        end
        default: begin
          count_d = '0;
        end
      endcase
    end

    if (emit) begin
      if (hold_v_q) begin
        out_v_d = 1'b1;
        out_d.out_byte = hold_b_q;
        out_d.last_of_burst = 1'b0;
      end
      hold_b_d = emit_b;
      hold_v_d = 1'b1;
    end

    if (cmd_i.finish && hold_v_q) begin
      out_v_d = 1'b1;
      out_d.out_byte = hold_b_q;
      out_d.last_of_burst = 1'b1;
      hold_v_d = 1'b0;
    end
  end

  sprle_ram #(
    .Width(8),
    .Depth(RUN_MAX)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx_d[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q <= '0;
      fill_q <= '0;
      slot0_v_q <= 1'b0;
      slot1_v_q <= 1'b0;
      eor_q <= 1'b0;
      count_q <= '0;
      repeat_q <= 1'b1;
      rv_q <= '0;
      seen_q <= '0;
      idx_q <= '0;
      post_q <= POST_NONE;
      hold_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      pack_q <= pack_d;
      fill_q <= fill_d;
      slot0_v_q <= slot0_v_d;
      slot1_v_q <= slot1_v_d;
      eor_q <= eor_d;
      count_q <= count_d;
      repeat_q <= repeat_d;
      rv_q <= rv_d;
      seen_q <= seen_d;
      idx_q <= idx_d;
      post_q <= post_d;
      hold_v_q <= hold_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_b_q <= slot0_b_d;
    slot1_b_q <= slot1_b_d;
    cb_q <= cb_d;
    hold_b_q <= hold_b_d;
    out_q <= out_d;
  end

  assign stat_o.slot_pending = slot0_v_q | slot1_v_q;
  assign stat_o.flush_pending = eor_q & (count_q != '0);
  assign stat_o.rle = rle_i;
  assign stat_o.needs_emit = needs_emit;
  assign stat_o.repeat_mode = repeat_q;
  assign stat_o.lit_last = ((idx_q + CNT_W'(1)) == count_q);
  assign stat_o.emit_ok = emit_ok;

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

endmodule

@@ sv/sample_pack_run_length_encoder_unit.sv @@
// Top level of the sample packer and run-length encoder: register port and assembly.
// Depends on sprle_pkg, sprle_ctrl and sprle_dp.
//
// Samples of 1, 2, 4 or 8 bits are packed most significant first into bytes, which go out
// as they are or run-length coded (runs as 256-count and the value, literal stretches as
// count-1 and the bytes). One sample is in work at a time, and a single sequencer steps
// through it with one byte per cycle on the output side while the output is not stalled:
// each completed byte is taken and then passed on or coded, putting out the buffer sends
// its header and then its value or bytes, and an end-of-row flush puts out the buffer too.
// The last byte of a sample is held one stage so that it can carry last_of_burst, and the
// output register lets the next sample enter while that byte waits to be taken.
module sample_pack_run_length_encoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sprle_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sprle_pkg::out_item_t          out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sprle_pkg::CFG_AW-1:0]  paddr,
  input  logic [sprle_pkg::CFG_DW-1:0]  pwdata,
  output logic [sprle_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready
);
  import sprle_pkg::*;

  logic [3:0] bps_q, bps_d;
  logic       rle_q, rle_d;
  logic       cfg_wr;
  cmd_t       cmd;
  stat_t      stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    bps_d = bps_q;
    rle_d = rle_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_BPS: bps_d = pwdata[3:0];
        REG_RLE: rle_d = pwdata[0];
        default: bps_d = bps_q;
      endcase
    end
  end

  always_comb begin
    if (paddr[2] == REG_RLE) begin
      prdata = {{(CFG_DW - 1){1'b0}}, rle_q};
    end else begin
      prdata = {{(CFG_DW - 4){1'b0}}, bps_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q <= 4'd8;
      rle_q <= 1'b0;
    end else begin
      bps_q <= bps_d;
      rle_q <= rle_d;
    end
  end

  sprle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sprle_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .bps_i      (bps_q),
    .rle_i      (rle_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // No byte may enter the hold stage unless the byte already there can move on.
  property p_emit_has_room;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd.direct || cmd.hdr || cmd.val || cmd.lit || cmd.finish) |-> stat.emit_ok;
  endproperty
  a_emit_has_room: assert property (p_emit_has_room)
    else $error("byte issued while the output stage is blocked");

  // Once a sample is taken, the input stays stalled for at least the next cycle.
  property p_busy_after_accept;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_stall_o) |=> in_stall_o;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("input taken again before the previous sample was worked off");

  // While the block is open for input, nothing is being coded or emitted.
  property p_idle_quiet;
    @(posedge clk_i) disable iff (!rst_ni)
      !in_stall_o |-> !(cmd.take || cmd.code || cmd.direct || cmd.hdr || cmd.lit || cmd.post);
  endproperty
  a_idle_quiet: assert property (p_idle_quiet)
    else $error("work commanded while the input side is open");

endmodule

@@ verif/sample_pack_run_length_encoder_unit_test.sv @@
// Self-checking testbench for sample_pack_run_length_encoder_unit: directed rows, then random rows
// under several idling patterns, checked beat by beat against a packing and run-length predictor.
// Depends on sprle_pkg and the RTL of the block; reads and writes no files.
module sample_pack_run_length_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sprle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned BURST_CAP = 64;
  localparam int unsigned RANDOM_ITEMS = 190;
  localparam logic [3:0] BPS_CHOICES [7] = '{4'd1, 4'd2, 4'd4, 4'd8, 4'd8, 4'd8, 4'd6};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  in_item_t            sample_q[$];
  out_item_t           coded_bytes_q[$];
  logic                in_taken;
  int unsigned         gap_pct;
  int unsigned         stall_pct;
  int unsigned         cycle_cnt;
  int unsigned         mismatch_cnt;
  out_item_t           want;

  // Predictor state: configuration copy, packer and run-length buffer.
  logic [3:0]          bps_q;
  logic                rle_q;
  logic [7:0]          pk_byte;
  logic [3:0]          pk_fill;
  logic [7:0]          hold_buf [RUN_MAX];
  logic [5:0]          hold_cnt;
  logic                run_mode;
  logic [7:0]          run_byte;
  logic [5:0]          same_cnt;
  int unsigned         burst_len;

  sample_pack_run_length_encoder_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function void put_byte(logic [7:0] b);
    if (burst_len < BURST_CAP) begin
      coded_bytes_q.push_back('{out_byte: b, last_of_burst: 1'b0});
      burst_len++;
    end
  endfunction

  function void hold_append(logic [7:0] b);
    if (hold_cnt < RUN_MAX) begin
      hold_buf[hold_cnt] = b;
      hold_cnt++;
    end
  endfunction

  function void flush_hold();
    int unsigned i;
    if (run_mode) begin
      if (hold_cnt > 0) begin
        put_byte(8'(256 - int'(hold_cnt)));
        put_byte(run_byte);
      end
    end else if (hold_cnt > 0) begin
      put_byte(8'(hold_cnt - 1));
      for (i = 0; i < hold_cnt; i++) put_byte(hold_buf[i]);
    end
    run_mode = 1'b1;
    hold_cnt = '0;
  endfunction

  function void code_byte(logic [7:0] b);
    int unsigned drop;
    int unsigned i;
    if (hold_cnt >= RUN_MAX) flush_hold();
    if (run_mode && hold_cnt == 0) begin
      run_byte = b;
      hold_append(b);
    end else if (run_mode) begin
      if (b == run_byte) begin
        hold_append(b);
      end else if (hold_cnt > 2) begin
        flush_hold();
        run_byte = b;
        hold_append(b);
      end else begin
        run_mode = 1'b0;
        run_byte = b;
        hold_append(b);
        same_cnt = 6'd1;
      end
    end else if (b == run_byte) begin
      if (same_cnt < 63) same_cnt++;
      if (same_cnt > 3) begin
        drop = same_cnt - 1;
        hold_cnt = (hold_cnt > drop) ? 6'(hold_cnt - drop) : 6'd0;
        flush_hold();
        hold_cnt = (same_cnt > RUN_MAX) ? 6'(RUN_MAX) : same_cnt;
        for (i = 0; i < hold_cnt; i++) hold_buf[i] = b;
      end else begin
        hold_append(b);
      end
    end else begin
      run_byte = b;
      hold_append(b);
      same_cnt = 6'd1;
    end
  endfunction

  function void pass_byte();
    if (rle_q) code_byte(pk_byte);
    else put_byte(pk_byte);
    pk_byte = '0;
    pk_fill = '0;
  endfunction

  function void encode_sample(in_item_t item);
    int unsigned w;
    int unsigned v;
    out_item_t tail;
    burst_len = 0;
    w = (bps_q inside {4'd1, 4'd2, 4'd4}) ? int'(bps_q) : 8;
    v = int'(item.sample_value) & ((1 << w) - 1);
    if (int'(pk_fill) + w > 8) pass_byte();
    pk_byte = pk_byte | 8'(v << (8 - int'(pk_fill) - w));
    pk_fill = 4'(int'(pk_fill) + w);
    if (pk_fill >= 8) pass_byte();
    if (item.end_of_row) begin
      if (pk_fill > 0) pass_byte();
      if (hold_cnt > 0) flush_hold();
    end
    if (burst_len > 0) begin
      tail = coded_bytes_q.pop_back();
      tail.last_of_burst = 1'b1;
      coded_bytes_q.push_back(tail);
    end
  endfunction

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_data <= sample_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt,
               coded_bytes_q.size());
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) encode_sample(in_data);
      if (out_valid && !out_stall) begin
        if (coded_bytes_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected beat: byte %h last %b", out_data.out_byte,
                     out_data.last_of_burst);
        end else begin
          want = coded_bytes_q.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.last_of_burst !== want.last_of_burst) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected byte %h last %b, got byte %h last %b",
                       want.out_byte, want.last_of_burst, out_data.out_byte,
                       out_data.last_of_burst);
          end
        end
      end
    end
  end

  task automatic settle();
    do @(posedge clk); while (sample_q.size() != 0 || in_valid || coded_bytes_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BPS) bps_q = value[3:0];
    else rle_q = value[0];
  endtask

  task automatic reconfigure(logic [3:0] bps, logic rle);
    settle();
    write_reg(REG_BPS, CFG_DW'(bps));
    write_reg(REG_RLE, CFG_DW'(rle));
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin gap_pct = 0; stall_pct = 0; end
      1: begin gap_pct = 55; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 55; end
      default: begin gap_pct = 15; stall_pct = 15; end
    endcase
  endtask

  task automatic push_sample(logic [7:0] value, logic eor);
    sample_q.push_back('{sample_value: value, end_of_row: eor});
  endtask

  initial begin
    int unsigned w;
    int unsigned mask;
    int unsigned spb;
    int unsigned nbytes;
    int unsigned p_rep;
    int unsigned n;
    int unsigned k;
    int unsigned j;
    int unsigned sent;
    int unsigned round;
    logic        eor_last;
    logic [3:0]  bps_pick;
    logic        rle_pick;
    logic [7:0]  cur;
    in_item_t    item;
    in_item_t    row_items[$];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    in_taken = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycle_cnt = 0;
    mismatch_cnt = 0;
    bps_q = 4'd8;
    rle_q = 1'b0;
    pk_byte = '0;
    pk_fill = '0;
    hold_cnt = '0;
    run_mode = 1'b1;
    run_byte = '0;
    same_cnt = '0;
    set_idling(0);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: 8-bit samples sent straight through.
    push_sample(8'h00, 1'b0);
    push_sample(8'hFF, 1'b1);

    // One-bit samples; the row ends on a partial byte.
    reconfigure(4'd1, 1'b0);
    push_sample(8'hFF, 1'b0);
    push_sample(8'h00, 1'b0);
    push_sample(8'hAB, 1'b0);
    push_sample(8'h54, 1'b0);
    push_sample(8'h01, 1'b1);

    // Width widened while six bits are pending.
    reconfigure(4'd2, 1'b0);
    push_sample(8'h03, 1'b0);
    push_sample(8'hFE, 1'b0);
    push_sample(8'h81, 1'b0);
    reconfigure(4'd4, 1'b0);
    push_sample(8'hF7, 1'b1);

    // Unused width acts as 8; a literal stretch turns into a run.
    reconfigure(4'd3, 1'b1);
    push_sample(8'h5A, 1'b0);
    push_sample(8'hC3, 1'b0);
    push_sample(8'hC3, 1'b0);
    push_sample(8'hC3, 1'b0);
    push_sample(8'hC3, 1'b0);

    // Coding switched off with the run still buffered.
    reconfigure(4'd3, 1'b0);
    push_sample(8'h11, 1'b1);

    reconfigure(4'd8, 1'b1);
    push_sample(8'h00, 1'b1);
    push_sample(8'hFF, 1'b0);
    push_sample(8'hFF, 1'b0);
    push_sample(8'hFF, 1'b1);

    sent = 0;
    round = 0;
    while (sent < RANDOM_ITEMS) begin
      set_idling(round % 4);
      bps_pick = BPS_CHOICES[$urandom_range(6)];
      rle_pick = ($urandom_range(99) < 75);
      reconfigure(bps_pick, rle_pick);
      w = (bps_pick inside {4'd1, 4'd2, 4'd4}) ? int'(bps_pick) : 8;
      mask = (1 << w) - 1;
      row_items.delete();
      eor_last = 1'b0;
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(12, 4);
        repeat (n) row_items.push_back('{sample_value: 8'($urandom),
                                         end_of_row: ($urandom_range(9) == 0)});
      end else begin
        spb = 8 / w;
        if (w == 8) nbytes = ($urandom_range(5) == 0) ? $urandom_range(40, 33)
                                                      : $urandom_range(12, 1);
        else nbytes = $urandom_range(4, 1);
        p_rep = $urandom_range(95);
        cur = 8'($urandom);
        repeat (nbytes) begin
          if ($urandom_range(99) >= p_rep)
            cur = ($urandom_range(1) == 0) ? 8'($urandom_range(3) * 85) : 8'($urandom);
          for (k = 0; k < spb; k++)
            row_items.push_back('{sample_value: 8'(($urandom & ~mask) |
                                                   ((int'(cur) >> (8 - w * (k + 1))) & mask)),
                                  end_of_row: 1'b0});
        end
        if (spb > 1 && $urandom_range(9) < 3) begin
          n = $urandom_range(spb - 1, 1);
          repeat (n) void'(row_items.pop_back());
        end
        eor_last = ($urandom_range(99) >= 15);
      end
      for (j = 0; j < row_items.size(); j++) begin
        item = row_items[j];
        if (eor_last && j == row_items.size() - 1) item.end_of_row = 1'b1;
        sample_q.push_back(item);
      end
      sent += row_items.size();
      round++;
    end

    settle();
    if (mismatch_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
